// File: rtl/sbeq_pkg.sv
package sbeq_pkg;

  // default configuration of the equaliser
  localparam int NUM_BANDS_DEF    = 3;
  localparam int NUM_CHANNELS_DEF = 2;

  // data path widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int COEF_SHIFT = 12;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 48;
  localparam int FF_W        = 48;
  localparam int FB_W        = 32;
  localparam int NUM_REGS    = 6;

  localparam logic [FF_W-1:0] UNITY_FF = FF_W'(4096);
  localparam logic [FB_W-1:0] ZERO_FB  = '0;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // sequencer steps
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_MUL0  = 3'd1;
  localparam step_t ST_MUL1  = 3'd2;
  localparam step_t ST_MUL2  = 3'd3;
  localparam step_t ST_MUL3  = 3'd4;
  localparam step_t ST_MUL4  = 3'd5;
  localparam step_t ST_FIN   = 3'd6;
  localparam step_t ST_EMIT  = 3'd7;

  // which coefficient and which operand go to the multiplier
  typedef enum logic [2:0] {
    T_B0X0,
    T_B1XH0,
    T_B2XH1,
    T_A1YH0,
    T_A2YH1
  } term_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // how the step counter moves on
  typedef enum logic [1:0] {
    C_NEXT,   // always to the following step
    C_IN,     // to target once an item is taken, else hold
    C_MORE,   // to target while sections remain, else following step
    C_OUT     // to target once the output register is free, else hold
  } cond_t;

  typedef struct packed {
    term_t   term;
    acc_op_t acc;
    logic    finish;
    cond_t   cond;
    step_t   target;
  } uword_t;

  // control store: one biquad section is steps mul0 to fin
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{term: T_B0X0, acc: ACC_NOP, finish: 1'b0, cond: C_IN, target: ST_MUL0};
    case (s)
      ST_IDLE: w = '{term: T_B0X0,  acc: ACC_NOP,  finish: 1'b0, cond: C_IN,
                     target: ST_MUL0};
      ST_MUL0: w = '{term: T_B0X0,  acc: ACC_NOP,  finish: 1'b0, cond: C_NEXT,
                     target: ST_IDLE};
      ST_MUL1: w = '{term: T_B1XH0, acc: ACC_LOAD, finish: 1'b0, cond: C_NEXT,
                     target: ST_IDLE};
      ST_MUL2: w = '{term: T_B2XH1, acc: ACC_ADD,  finish: 1'b0, cond: C_NEXT,
                     target: ST_IDLE};
      ST_MUL3: w = '{term: T_A1YH0, acc: ACC_ADD,  finish: 1'b0, cond: C_NEXT,
                     target: ST_IDLE};
      ST_MUL4: w = '{term: T_A2YH1, acc: ACC_SUB,  finish: 1'b0, cond: C_NEXT,
                     target: ST_IDLE};
      ST_FIN:  w = '{term: T_B0X0,  acc: ACC_SUB,  finish: 1'b1, cond: C_MORE,
                     target: ST_MUL0};
      ST_EMIT: w = '{term: T_B0X0,  acc: ACC_NOP,  finish: 1'b0, cond: C_OUT,
                     target: ST_IDLE};
      default: w = '{term: T_B0X0,  acc: ACC_NOP,  finish: 1'b0, cond: C_IN,
                     target: ST_MUL0};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/stereo_three_band_biquad_eq.sv
// channel   direction  handshake                  payload
// sample    in         sample_valid/sample_stall  left_sample, right_sample
// result    out        result_valid/result_stall  left_result, right_result
// config    in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// an item passes the idle step, where it is taken, then steps mul0 to fin
// for each biquad section in turn on the single shared multiplier, then the
// emit step, which hands the result to the output register
// the output register holds the last result while the next item is worked on
// rst is synchronous: clears history, restores unity coefficients, empties output
// sample_stall is low only while the sequencer waits at its idle step; a
// stalled result holds the sequencer at its emit step
module stereo_three_band_biquad_eq #(
  parameter int NUM_BANDS    = sbeq_pkg::NUM_BANDS_DEF,
  parameter int NUM_CHANNELS = sbeq_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0]   left_sample,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0]   right_sample,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0]   left_result,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0]   right_result,
  // coefficient write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sbeq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sbeq_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int NUM_SECS = NUM_BANDS * NUM_CHANNELS;
  localparam int BW       = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW       = (NUM_SECS > 1) ? $clog2(NUM_SECS) : 1;
  localparam int SMP      = sbeq_pkg::SAMPLE_W;

  // history of one section: two past inputs and two past outputs
  typedef struct packed {
    logic signed [SMP-1:0] xh0;
    logic signed [SMP-1:0] xh1;
    logic signed [SMP-1:0] yh0;
    logic signed [SMP-1:0] yh1;
  } hist_t;

  // coefficients, one feedforward and one feedback word per band
  logic [sbeq_pkg::FF_W-1:0] ff [NUM_BANDS];
  logic [sbeq_pkg::FB_W-1:0] fb [NUM_BANDS];

  // section history, indexed by channel * NUM_BANDS + band
  hist_t hist [NUM_SECS];

  // sequencer
  sbeq_pkg::step_t  pc;
  sbeq_pkg::step_t  pc_next;
  sbeq_pkg::uword_t uw;
  logic [BW-1:0]    band;
  logic [CW-1:0]    ch;
  logic [SW-1:0]    sec;

  // datapath
  logic signed [SMP-1:0]                  x0;        // input of current section
  logic signed [SMP-1:0]                  x_right;   // right sample waiting its turn
  logic signed [SMP-1:0]                  res_left;
  logic signed [SMP-1:0]                  res_right;
  logic signed [sbeq_pkg::PROD_W-1:0]     prod;
  logic signed [sbeq_pkg::ACC_W-1:0]      acc;
  logic signed [sbeq_pkg::ACC_W-1:0]      acc_fin;
  logic signed [sbeq_pkg::ACC_W-1:0]      q;
  logic signed [SMP-1:0]                  y;
  logic signed [sbeq_pkg::COEF_W-1:0]     coef;
  logic signed [SMP-1:0]                  opnd;
  hist_t                                  cur;

  logic                          take_in;
  logic                          out_free;
  logic                          last_band;
  logic                          more;
  logic [sbeq_pkg::CFG_INDEX_W-2:0] cfg_band;
  logic                          cfg_hit;

  assign uw        = sbeq_pkg::ucode(pc);
  assign cur       = hist[sec];
  assign take_in   = sample_valid && !sample_stall;
  assign out_free  = !result_valid || !result_stall;
  assign last_band = (band == BW'(NUM_BANDS - 1));
  assign more      = !(last_band && (ch == CW'(NUM_CHANNELS - 1)));

  assign sample_stall = (pc != sbeq_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;

  // register index: bit 0 picks feedforward or feedback, the rest the band
  assign cfg_band = cfg_index[sbeq_pkg::CFG_INDEX_W-1:1];
  assign cfg_hit  = cfg_valid && cfg_ready
                    && (cfg_index < sbeq_pkg::CFG_INDEX_W'(sbeq_pkg::NUM_REGS))
                    && (int'(cfg_band) < NUM_BANDS);

  // multiplier operand selection for the current term
  always_comb begin
    case (uw.term)
      sbeq_pkg::T_B0X0: begin
        coef = ff[band][15:0];
        opnd = x0;
      end
      sbeq_pkg::T_B1XH0: begin
        coef = ff[band][31:16];
        opnd = cur.xh0;
      end
      sbeq_pkg::T_B2XH1: begin
        coef = ff[band][47:32];
        opnd = cur.xh1;
      end
      sbeq_pkg::T_A1YH0: begin
        coef = fb[band][15:0];
        opnd = cur.yh0;
      end
      sbeq_pkg::T_A2YH1: begin
        coef = fb[band][31:16];
        opnd = cur.yh1;
      end
      default: begin
        coef = '0;
        opnd = '0;
      end
    endcase
  end

  // last feedback term folds straight into the scaling shift and clamp
  assign acc_fin = acc - sbeq_pkg::ACC_W'(prod);
  assign q       = acc_fin >>> sbeq_pkg::COEF_SHIFT;

  always_comb begin
    if ((q[sbeq_pkg::ACC_W-1:SMP-1] == '0) || (q[sbeq_pkg::ACC_W-1:SMP-1] == '1)) begin
      y = q[SMP-1:0];
    end else if (q[sbeq_pkg::ACC_W-1]) begin
      y = sbeq_pkg::SAT_MIN;
    end else begin
      y = sbeq_pkg::SAT_MAX;
    end
  end

  // next step from the control word's condition
  always_comb begin
    case (uw.cond)
      sbeq_pkg::C_NEXT: pc_next = sbeq_pkg::step_t'(pc + 3'd1);
      sbeq_pkg::C_IN:   pc_next = take_in ? uw.target : pc;
      sbeq_pkg::C_MORE: pc_next = more ? uw.target : sbeq_pkg::step_t'(pc + 3'd1);
      sbeq_pkg::C_OUT:  pc_next = out_free ? uw.target : pc;
      default:          pc_next = sbeq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // multiplier runs every cycle, product registered
    prod <= coef * opnd;

    if (rst) begin
      pc           <= sbeq_pkg::ST_IDLE;
      band         <= '0;
      ch           <= '0;
      sec          <= '0;
      result_valid <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        ff[b] <= sbeq_pkg::UNITY_FF;
        fb[b] <= sbeq_pkg::ZERO_FB;
      end
      for (int s = 0; s < NUM_SECS; s++) begin
        hist[s] <= '0;
      end
    end else begin
      pc <= pc_next;

      if (cfg_hit) begin
        if (cfg_index[0]) begin
          fb[cfg_band[BW-1:0]] <= cfg_data[sbeq_pkg::FB_W-1:0];
        end else begin
          ff[cfg_band[BW-1:0]] <= cfg_data[sbeq_pkg::FF_W-1:0];
        end
      end

      if (take_in) begin
        band    <= '0;
        ch      <= '0;
        sec     <= '0;
        x0      <= left_sample;
        x_right <= right_sample;
      end

      case (uw.acc)
        sbeq_pkg::ACC_LOAD: acc <= sbeq_pkg::ACC_W'(prod);
        sbeq_pkg::ACC_ADD:  acc <= acc + sbeq_pkg::ACC_W'(prod);
        sbeq_pkg::ACC_SUB:  acc <= acc_fin;
        default:            acc <= acc;
      endcase

      // end of a section: shift history, move on to next band or channel
      if (uw.finish) begin
        hist[sec] <= '{xh0: x0, xh1: cur.xh0, yh0: y, yh1: cur.yh0};
        sec       <= SW'(sec + 1'b1);
        if (last_band) begin
          band <= '0;
          ch   <= CW'(ch + 1'b1);
          x0   <= x_right;
          if (ch == '0) begin
            res_left <= y;
          end else begin
            res_right <= y;
          end
        end else begin
          band <= BW'(band + 1'b1);
          x0   <= y;
        end
      end

      // output register
      if ((pc == sbeq_pkg::ST_EMIT) && out_free) begin
        result_valid <= 1'b1;
        left_result  <= res_left;
        right_result <= (NUM_CHANNELS > 1) ? res_right : '0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // a fresh result only ever comes from the emit step
  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pc) == sbeq_pkg::ST_EMIT)
    else $error("result raised outside emit step");

  // section counter tracks channel and band while sections are running
  a_sec_track: assert property (@(posedge clk) disable iff (rst)
    (pc != sbeq_pkg::ST_IDLE && pc != sbeq_pkg::ST_EMIT)
    |-> int'(sec) == int'(ch) * NUM_BANDS + int'(band))
    else $error("section index out of step with channel and band");

  // a taken item always starts at the first section
  a_start: assert property (@(posedge clk) disable iff (rst)
    take_in |=> (pc == sbeq_pkg::ST_MUL0) && (sec == '0) && (band == '0) && (ch == '0))
    else $error("item did not start at first section");

  // after the last section the sequencer goes to emit
  a_last_to_emit: assert property (@(posedge clk) disable iff (rst)
    (pc == sbeq_pkg::ST_FIN && !more) |=> pc == sbeq_pkg::ST_EMIT)
    else $error("last section not followed by emit");

  // the emit step is left only when the output register took the result
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (pc == sbeq_pkg::ST_EMIT && !out_free) |=> pc == sbeq_pkg::ST_EMIT)
    else $error("emit step left while output register busy");

endmodule
